>>> hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Shared codes, reset values, coil tables and controller/datapath links.
// ----------------------------------------------------------------------------
package sps_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
	localparam logic [1:0] REG_SPEED_RPM     = 2'd1;
	localparam logic [1:0] REG_HALF_STEP     = 2'd2;
	localparam logic [1:0] REG_FOUR_WIRE     = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [11:0] SPR_RESET = 12'd200;

	// Milliseconds per minute, the dividend of the period computation.
	localparam int          QUO_W      = 16;
	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam int          DVSR_W     = 23;
	localparam int          ITER_W     = 4;

	function automatic logic [3:0] full4_coils(input logic [1:0] ph);
		logic [3:0] c;
		case (ph)
			2'd0:    c = 4'h5;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'hA;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] half4_coils(input logic [2:0] ph);
		logic [3:0] c;
		case (ph)
			3'd0:    c = 4'h5;
			3'd1:    c = 4'h4;
			3'd2:    c = 4'h6;
			3'd3:    c = 4'h2;
			3'd4:    c = 4'hA;
			3'd5:    c = 4'h8;
			3'd6:    c = 4'h9;
			default: c = 4'h1;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] two_coils(input logic [1:0] ph);
		logic [3:0] c;
		case (ph)
			2'd0:    c = 4'h2;
			2'd1:    c = 4'h3;
			2'd2:    c = 4'h1;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic div_load;  // register divisor product, clear the divider
		logic div_step;  // one restoring division step
		logic apply;     // update motor state and load the result register
	} sps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;  // captured item is a start with nonzero speed
		logic div_last;  // the divider is on its final step
	} sps_sts_t;

endpackage

>>> hdl/sps_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface sps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic        backward;
	logic [15:0] step_count;

	modport source (output valid, operation, backward, step_count, input ready);
	modport sink   (input valid, operation, backward, step_count, output ready);
endinterface

>>> hdl/sps_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item per input item.
// ----------------------------------------------------------------------------
interface sps_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] coils;
	logic       busy_res;
	logic       stepped;

	modport source (output valid, coils, busy_res, stepped, input ready);
	modport sink   (input valid, coils, busy_res, stepped, output ready);
endinterface

>>> hdl/sps_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sps_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// Stepper sequencer controller
// Sequences capture, period division and state update of one item.
// ----------------------------------------------------------------------------
module sps_ctrl
	import sps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  sps_sts_t sts,
	output sps_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.need_div) begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/sps_dpath.sv
// ----------------------------------------------------------------------------
// Stepper sequencer datapath
// Configuration, restoring divider, phase and counter state, result register.
// ----------------------------------------------------------------------------
module sps_dpath
	import sps_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            operation,
	input  logic                  backward,
	input  logic [15:0]           step_count,
	input  sps_cmd_t              cmd,
	output sps_sts_t              sts,
	output logic [3:0]            coils,
	output logic                  busy_res,
	output logic                  stepped
);

	localparam logic [31:0] CMASK = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

	// Configuration registers.
	logic [11:0] spr_q;
	logic [9:0]  speed_q;
	logic        half_q;
	logic        four_q;

	// Captured item.
	logic [1:0]  op_q;
	logic        back_q;
	logic [15:0] cnt_q;

	// Motor state.
	logic [2:0]            phase_q;
	logic [COUNT_BITS-1:0] steps_q;
	logic [COUNT_BITS-1:0] delay_q;
	logic [COUNT_BITS-1:0] period_q;
	logic                  mback_q;
	logic [3:0]            coil_q;

	// Divider.
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ITER_W-1:0] iter_q;

	logic              half_mode;
	logic [12:0]       div_base;
	logic [12:0]       div_eff;
	logic [DVSR_W-1:0] prod;
	logic [DVSR_W:0]   shifted;
	logic [DVSR_W+1:0] diff;

	assign half_mode = half_q && four_q;
	assign div_base  = (spr_q == '0) ? 13'd1 : {1'b0, spr_q};
	assign div_eff   = half_mode ? {div_base[11:0], 1'b0} : div_base;
	assign prod      = DVSR_W'(div_eff * speed_q);
	assign shifted   = {rem_q, quo_q[QUO_W-1]};
	assign diff      = {1'b0, shifted} - {2'b00, dvsr_q};

	assign sts.need_div = (op_q == OP_START) && (speed_q != '0);
	assign sts.div_last = (iter_q == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q   <= SPR_RESET;
			speed_q <= '0;
			half_q  <= 1'b0;
			four_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEPS_PER_REV: spr_q   <= cfg_data;
				REG_SPEED_RPM:     speed_q <= cfg_data[9:0];
				REG_HALF_STEP:     half_q  <= cfg_data[0];
				REG_FOUR_WIRE:     four_q  <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			back_q <= backward;
			cnt_q  <= step_count;
		end
		if (cmd.div_load) begin
			dvsr_q <= prod;
			rem_q  <= '0;
			quo_q  <= MS_PER_MIN;
			iter_q <= '0;
		end else if (cmd.div_step) begin
			iter_q <= iter_q + 1'b1;
			if (!diff[DVSR_W+1]) begin
				rem_q <= diff[DVSR_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVSR_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	// Next-state logic of one item.
	logic [COUNT_BITS-1:0] period_new;
	logic [COUNT_BITS-1:0] cnt_sat;
	logic                  dir_back;
	logic [2:0]            ph_raw;
	logic [2:0]            ph_step;
	logic [3:0]            coil_step;
	logic                  do_step;
	logic [2:0]            phase_d;
	logic [COUNT_BITS-1:0] steps_d;
	logic [COUNT_BITS-1:0] delay_d;
	logic [COUNT_BITS-1:0] period_d;
	logic                  mback_d;
	logic [3:0]            coil_d;

	assign period_new = (32'(quo_q) > CMASK) ? CMASK[COUNT_BITS-1:0] : COUNT_BITS'(quo_q);
	assign cnt_sat    = (32'(cnt_q) > CMASK) ? CMASK[COUNT_BITS-1:0] : COUNT_BITS'(cnt_q);
	assign dir_back   = (op_q == OP_START) ? back_q : mback_q;
	assign ph_raw     = dir_back ? (phase_q - 3'd1) : (phase_q + 3'd1);
	assign ph_step    = half_mode ? ph_raw : {1'b0, ph_raw[1:0]};

	always_comb begin
		if (!four_q) begin
			coil_step = two_coils(ph_step[1:0]);
		end else if (half_mode) begin
			coil_step = half4_coils(ph_step);
		end else begin
			coil_step = full4_coils(ph_step[1:0]);
		end
	end

	always_comb begin
		do_step  = 1'b0;
		steps_d  = steps_q;
		delay_d  = delay_q;
		period_d = period_q;
		mback_d  = mback_q;
		coil_d   = coil_q;
		case (op_q)
			OP_START: begin
				if (speed_q != '0) begin
					period_d = period_new;
					mback_d  = back_q;
					if (cnt_sat != '0) begin
						do_step = 1'b1;
						steps_d = cnt_sat - 1'b1;
						delay_d = period_new;
					end else begin
						steps_d = '0;
						delay_d = '0;
					end
				end
			end
			OP_TICK: begin
				if (steps_q != '0) begin
					if (delay_q <= COUNT_BITS'(1)) begin
						do_step = 1'b1;
						steps_d = steps_q - 1'b1;
						delay_d = period_q;
					end else begin
						delay_d = delay_q - 1'b1;
					end
				end
			end
			OP_STOP: begin
				coil_d  = '0;
				steps_d = '0;
				delay_d = '0;
			end
			default: ;
		endcase
		phase_d = do_step ? ph_step : phase_q;
		if (do_step) begin
			coil_d = coil_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			steps_q  <= '0;
			delay_q  <= '0;
			period_q <= '0;
			mback_q  <= 1'b0;
			coil_q   <= '0;
		end else if (cmd.apply) begin
			phase_q  <= phase_d;
			steps_q  <= steps_d;
			delay_q  <= delay_d;
			period_q <= period_d;
			mback_q  <= mback_d;
			coil_q   <= coil_d;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			coils    <= coil_d;
			busy_res <= (steps_d != '0);
			stepped  <= do_step;
		end
	end

endmodule

>>> hdl/stepper_phase_sequencer_core.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer core
// Full-step and half-step coil sequencer for four-wire and two-wire steppers.
// ----------------------------------------------------------------------------
// A tick, a stop or a start with zero speed goes from its transfer through
// the prepare and execute states to the result register; a start with
// nonzero speed also runs the bit-serial period divider, which forms the 16
// quotient bits one per step. One item is in work at a time, so no new item
// is taken until the last one has loaded its result, and a waiting result
// holds the execute state. Reset clears the phase, counters and coils and
// loads the register defaults; there is no clearing pass, items flow at once.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_core
	import sps_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input logic    clk,
	input logic    arst_n,
	sps_in_if.sink   in_ch,
	sps_out_if.source out_ch,
	sps_cfg_if.sink  cfg
);

	sps_cmd_t cmd;
	sps_sts_t sts;

	// Configuration writes land directly in the datapath registers; the port never stalls.
	// The user must issue them only while the block is idle; the block does not enforce it.
	assign cfg.ready = 1'b1;

	// The controller owns both handshakes: it takes an item in its idle state,
	// walks it through the divider when a start needs a new period, and loads
	// the result register once that register is free. The result register
	// lets the next item be taken while a result waits, but that item then
	// holds in the execute state until the waiting result is taken.
	sps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath forms the period as 60000 divided by the product of the
	// effective steps per revolution and the speed, which equals the two
	// successive integer divisions of the motor formula. Phase, step and delay
	// counters and the coil pattern are updated together when an item is applied.
	sps_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.operation  (in_ch.operation),
		.backward   (in_ch.backward),
		.step_count (in_ch.step_count),
		.cmd        (cmd),
		.sts        (sts),
		.coils      (out_ch.coils),
		.busy_res   (out_ch.busy_res),
		.stepped    (out_ch.stepped)
	);

endmodule
